[rtl/qgap_pkg.sv]
// Shared types, constants and register codes for the quantised global average pool.
// Depends on nothing; every other file in rtl but qgap_ram imports it.
package qgap_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int OUT_CH_W     = 12;
    localparam int PIX_W        = 8;
    localparam int IMG_W        = 24;
    localparam int CNT_CH_W     = 13;
    localparam int ACC_W        = 33;
    localparam int MAG_W        = 32;
    localparam int MULT_W       = 24;
    localparam int SHIFT_W      = 6;
    localparam int PROD_W       = MAG_W + MULT_W;
    localparam int WIDE_W       = 64;
    localparam int Q_W          = 10;
    localparam int V_W          = 12;
    localparam int PIX_MAX      = 255;

    localparam int NUM_REGS     = 7;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = $clog2(NUM_REGS * 4);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic LAYOUT_CHAN_MAJOR = 1'b0;
    localparam logic LAYOUT_PIX_MAJOR  = 1'b1;

    typedef enum logic [2:0] {
        REG_LAYOUT   = 3'd0,
        REG_CHANNELS = 3'd1,
        REG_IMAGE    = 3'd2,
        REG_ZP_IN    = 3'd3,
        REG_ZP_OUT   = 3'd4,
        REG_MULT     = 3'd5,
        REG_SHIFT    = 3'd6
    } t_reg_idx;

    // Configuration as the datapath sees it, with the degenerate counts resolved.
    typedef struct packed {
        logic                     layout;
        logic [CH_W-1:0]          nch_m1;
        logic [IMG_W-1:0]         npix_m1;
        logic [PIX_W-1:0]         zp_out;
        logic [MULT_W-1:0]        scale_mult;
        logic [SHIFT_W-1:0]       scale_shift;
        logic signed [ACC_W-1:0]  bias;
    } t_cfg;

    // One classified activation byte travelling from front to back.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CH_W-1:0]  ch;
        logic             first;
        logic             last_pix;
        logic             last_ch;
    } t_item;

endpackage

[rtl/quantized_global_average_pool_core.sv]
// Top level of the quantised global average pool: register port, front end, queue, back end.
// Depends on qgap_pkg, qgap_regs, qgap_front, qgap_queue, qgap_back (and qgap_ram below it).
//
// Streams uint8 activations one byte per transaction and returns one requantised
// average per channel. Set layout, channel_count, image_size, both zero points and
// the scale (mantissa and right shift) through the register port while the block is
// idle; every write to a defined register restarts the image, so the next byte is
// pixel 0 of channel 0. Sustained rate is one byte per clock while the output is not
// stalled: each byte costs one read-modify-write of its channel's accumulator, and in
// pixel-major layout the 4096 x 33-bit accumulator store is read the cycle before the
// add and written at the add, with the sum of the item just ahead forwarded when it
// hit the same channel. After the channel's last byte is accepted, the result passes
// through the queue, accumulate, magnitude, multiply, shift-and-round and clamp. The store needs
// no clearing pass: the first pixel of an image always loads the starting sum.
// A four-entry queue separates the byte counters from the arithmetic, so input
// stays open while a finished result waits to be taken, until the queue fills.
module quantized_global_average_pool_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qgap_pkg::APB_AW-1:0]   paddr,
    input  logic [qgap_pkg::APB_DW-1:0]   pwdata,
    output logic [qgap_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // activation input
    input  logic                          i_pixel_valid,
    output logic                          o_pixel_stall,
    input  logic [qgap_pkg::PIX_W-1:0]    i_pixel_value,
    // pooled output
    output logic                          o_pooled_valid,
    input  logic                          i_pooled_stall,
    output logic [qgap_pkg::PIX_W-1:0]    o_pooled_value,
    output logic [qgap_pkg::OUT_CH_W-1:0] o_channel_index,
    output logic                          o_last_of_image
);
    import qgap_pkg::*;

    t_cfg  w_cfg;
    logic  w_restart;
    logic  w_push;
    t_item w_item;
    t_item w_head;
    logic  w_pop;
    logic  w_empty;
    logic  w_full;

    // Hold the settings; flag a restart on every defined write.
    qgap_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_restart (w_restart)
    );

    // Stall input only when the queue is full.
    assign o_pixel_stall = w_full;

    // Advance the pixel and channel counters and tag each byte with its position.
    qgap_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_restart     (w_restart),
        .i_pixel_valid (i_pixel_valid),
        .i_pixel_value (i_pixel_value),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_item)
    );

    // Decouple the counters from the arithmetic pipeline.
    qgap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Accumulate and requantise; the whole pipeline holds while a result waits.
    qgap_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_pooled_valid  (o_pooled_valid),
        .i_pooled_stall  (i_pooled_stall),
        .o_pooled_value  (o_pooled_value),
        .o_channel_index (o_channel_index),
        .o_last_of_image (o_last_of_image)
    );

endmodule

[rtl/qgap_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the per-channel accumulator store.
module qgap_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/qgap_regs.sv]
// APB-style configuration registers and the derived datapath settings.
// Depends on qgap_pkg.
module qgap_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qgap_pkg::APB_AW-1:0]   paddr,
    input  logic [qgap_pkg::APB_DW-1:0]   pwdata,
    output logic [qgap_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output qgap_pkg::t_cfg                o_cfg,
    output logic                          o_restart
);
    import qgap_pkg::*;

    logic                 r_layout;
    logic [CNT_CH_W-1:0]  r_channels;
    logic [IMG_W-1:0]     r_image;
    logic [PIX_W-1:0]     r_zp_in;
    logic [PIX_W-1:0]     r_zp_out;
    logic [MULT_W-1:0]    r_mult;
    logic [SHIFT_W-1:0]   r_shift;
    logic signed [ACC_W-1:0] r_bias;

    logic                 w_wr;
    t_reg_idx             w_idx;
    logic [IMG_W-1:0]     w_npix;
    logic [MAG_W-1:0]     w_zp_prod;
    logic [CH_W-1:0]      w_nch_m1;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout   <= LAYOUT_CHAN_MAJOR;
            r_channels <= CNT_CH_W'(1);
            r_image    <= IMG_W'(1);
            r_zp_in    <= '0;
            r_zp_out   <= '0;
            r_mult     <= MULT_W'(24'h800000);
            r_shift    <= SHIFT_W'(31);
        end else if (w_wr) begin
            case (w_idx)
                REG_LAYOUT:   r_layout   <= pwdata[0];
                REG_CHANNELS: r_channels <= pwdata[CNT_CH_W-1:0];
                REG_IMAGE:    r_image    <= pwdata[IMG_W-1:0];
                REG_ZP_IN:    r_zp_in    <= pwdata[PIX_W-1:0];
                REG_ZP_OUT:   r_zp_out   <= pwdata[PIX_W-1:0];
                REG_MULT:     r_mult     <= pwdata[MULT_W-1:0];
                REG_SHIFT:    r_shift    <= pwdata[SHIFT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Any write to a defined register restarts the image.
    always_comb begin
        case (w_idx)
            REG_LAYOUT, REG_CHANNELS, REG_IMAGE, REG_ZP_IN,
            REG_ZP_OUT, REG_MULT, REG_SHIFT: o_restart = w_wr;
            default:                         o_restart = 1'b0;
        endcase
    end

    always_comb begin
        case (w_idx)
            REG_LAYOUT:   prdata = APB_DW'(r_layout);
            REG_CHANNELS: prdata = APB_DW'(r_channels);
            REG_IMAGE:    prdata = APB_DW'(r_image);
            REG_ZP_IN:    prdata = APB_DW'(r_zp_in);
            REG_ZP_OUT:   prdata = APB_DW'(r_zp_out);
            REG_MULT:     prdata = APB_DW'(r_mult);
            REG_SHIFT:    prdata = APB_DW'(r_shift);
            default:      prdata = '0;
        endcase
    end

    assign w_npix = (r_image == '0) ? IMG_W'(1) : r_image;

    always_comb begin
        if (r_channels == '0) begin
            w_nch_m1 = '0;
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            w_nch_m1 = CH_W'(MAX_CHANNELS - 1);
        end else begin
            w_nch_m1 = CH_W'(r_channels - CNT_CH_W'(1));
        end
    end

    // Starting sum of every channel, registered from the input zero point and image size.
    assign w_zp_prod = MAG_W'(r_zp_in) * MAG_W'(w_npix);

    always_ff @(posedge i_clk) begin
        r_bias <= -$signed({1'b0, w_zp_prod});
    end

    assign o_cfg.layout      = r_layout;
    assign o_cfg.nch_m1      = w_nch_m1;
    assign o_cfg.npix_m1     = w_npix - IMG_W'(1);
    assign o_cfg.zp_out      = r_zp_out;
    assign o_cfg.scale_mult  = r_mult;
    assign o_cfg.scale_shift = r_shift;
    assign o_cfg.bias        = r_bias;

endmodule

[rtl/qgap_front.sv]
// Front end: accept activation bytes, track pixel and channel position, classify each byte.
// Depends on qgap_pkg.
module qgap_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  qgap_pkg::t_cfg         i_cfg,
    input  logic                   i_restart,
    input  logic                   i_pixel_valid,
    input  logic [qgap_pkg::PIX_W-1:0] i_pixel_value,
    input  logic                   i_full,
    output logic                   o_push,
    output qgap_pkg::t_item        o_item
);
    import qgap_pkg::*;

    logic [IMG_W-1:0] r_pix_cnt;
    logic [CH_W-1:0]  r_ch_cnt;
    logic [IMG_W-1:0] n_pix_cnt;
    logic [CH_W-1:0]  n_ch_cnt;
    logic             w_last_pix;
    logic             w_last_ch;

    assign o_push     = i_pixel_valid && !i_full;
    assign w_last_pix = (r_pix_cnt == i_cfg.npix_m1);
    assign w_last_ch  = (r_ch_cnt == i_cfg.nch_m1);

    assign o_item.pix      = i_pixel_value;
    assign o_item.ch       = r_ch_cnt;
    assign o_item.first    = (r_pix_cnt == '0);
    assign o_item.last_pix = w_last_pix;
    assign o_item.last_ch  = w_last_ch;

    always_comb begin
        n_pix_cnt = r_pix_cnt;
        n_ch_cnt  = r_ch_cnt;
        if (i_cfg.layout == LAYOUT_CHAN_MAJOR) begin
            if (w_last_pix) begin
                n_pix_cnt = '0;
                n_ch_cnt  = w_last_ch ? '0 : r_ch_cnt + CH_W'(1);
            end else begin
                n_pix_cnt = r_pix_cnt + IMG_W'(1);
            end
        end else begin
            if (w_last_ch) begin
                n_ch_cnt  = '0;
                n_pix_cnt = w_last_pix ? '0 : r_pix_cnt + IMG_W'(1);
            end else begin
                n_ch_cnt  = r_ch_cnt + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pix_cnt <= '0;
            r_ch_cnt  <= '0;
        end else if (o_push) begin
            r_pix_cnt <= n_pix_cnt;
            r_ch_cnt  <= n_ch_cnt;
        end
    end

    a_pix_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_cnt <= i_cfg.npix_m1)
        else $error("pixel counter beyond image size");

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch_cnt <= i_cfg.nch_m1)
        else $error("channel counter beyond channel count");

endmodule

[rtl/qgap_queue.sv]
// Short flop-based queue of classified items between front and back.
// Depends on qgap_pkg.
module qgap_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qgap_pkg::t_item i_item,
    input  logic            i_pop,
    output qgap_pkg::t_item o_head,
    output logic            o_empty,
    output logic            o_full
);
    import qgap_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy exceeds depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("push lost or occupancy miscounted");

endmodule

[rtl/qgap_back.sv]
// Back end: accumulate, requantise with round-half-to-even, clamp and present results.
// Depends on qgap_pkg and qgap_ram.
module qgap_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qgap_pkg::t_cfg                i_cfg,
    input  qgap_pkg::t_item               i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_pooled_valid,
    input  logic                          i_pooled_stall,
    output logic [qgap_pkg::PIX_W-1:0]    o_pooled_value,
    output logic [qgap_pkg::OUT_CH_W-1:0] o_channel_index,
    output logic                          o_last_of_image
);
    import qgap_pkg::*;

    logic w_adv;

    // Stage 1: classified item, store read data arrives alongside
    logic                    r_s1_valid;
    t_item                   r_s1;
    logic signed [ACC_W-1:0] r_single;
    logic [ACC_W-1:0]        w_rdata;
    logic                    w_fwd;
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] w_sum;
    logic                    w_we;

    // Stage 2: finished sum
    logic                    r_s2_valid;
    logic                    r_s2_emit;
    logic signed [ACC_W-1:0] r_s2_sum;
    logic [CH_W-1:0]         r_s2_ch;
    logic                    r_s2_last_ch;
    logic [ACC_W-1:0]        w_neg_sum;

    // Stage 3: magnitude
    logic                    r_s3_valid;
    logic [MAG_W-1:0]        r_s3_mag;
    logic                    r_s3_neg;
    logic [CH_W-1:0]         r_s3_ch;
    logic                    r_s3_last_ch;

    // Stage 4: scaled product
    logic                    r_s4_valid;
    logic [PROD_W-1:0]       r_s4_prod;
    logic                    r_s4_neg;
    logic [CH_W-1:0]         r_s4_ch;
    logic                    r_s4_last_ch;
    logic [WIDE_W-1:0]       w_prod;
    logic [WIDE_W-1:0]       w_shifted;
    logic [WIDE_W-1:0]       w_half;
    logic                    w_round_up;

    // Stage 5: shifted quotient and rounding decision
    logic                    r_s5_valid;
    logic [Q_W-1:0]          r_s5_q;
    logic                    r_s5_hi;
    logic                    r_s5_ru;
    logic                    r_s5_neg;
    logic [CH_W-1:0]         r_s5_ch;
    logic                    r_s5_last_ch;
    logic [Q_W:0]            w_q_inc;
    logic [Q_W-1:0]          w_q_sat;
    logic signed [V_W-1:0]   w_val;
    logic [PIX_W-1:0]        w_clamped;

    // Output register
    logic                    r_out_valid;
    logic [PIX_W-1:0]        r_out_value;
    logic [CH_W-1:0]         r_out_ch;
    logic                    r_out_last;

    assign w_adv = !r_out_valid || !i_pooled_stall;
    assign o_pop = w_adv && !i_empty;

    qgap_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1.ch),
        .i_wdata (w_sum),
        .i_re    (w_adv),
        .i_raddr (i_head.ch),
        .o_rdata (w_rdata)
    );

    // The item now in stage 2 wrote its entry at the edge this one was read; take its sum.
    assign w_fwd = r_s2_valid && (r_s2_ch == r_s1.ch);

    always_comb begin
        if (r_s1.first) begin
            w_base = i_cfg.bias;
        end else if (i_cfg.layout == LAYOUT_CHAN_MAJOR) begin
            w_base = r_single;
        end else if (w_fwd) begin
            w_base = r_s2_sum;
        end else begin
            w_base = $signed(w_rdata);
        end
    end

    assign w_sum = w_base + $signed({{(ACC_W-PIX_W){1'b0}}, r_s1.pix});
    assign w_we  = w_adv && r_s1_valid && (i_cfg.layout == LAYOUT_PIX_MAJOR);

    assign w_neg_sum = ACC_W'(0) - r_s2_sum;

    // Round half to even: up when the half bit is set and either a lower bit
    // is set or the quotient is odd. A zero shift has no half bit.
    assign w_prod     = WIDE_W'(r_s4_prod);
    assign w_shifted  = w_prod >> i_cfg.scale_shift;
    assign w_half     = (i_cfg.scale_shift == '0) ? '0
                      : (WIDE_W'(1) << (i_cfg.scale_shift - SHIFT_W'(1)));
    assign w_round_up = (|(w_prod & w_half))
                     && ((|(w_prod & (w_half - WIDE_W'(1)))) || w_shifted[0]);

    assign w_q_inc = {1'b0, r_s5_q} + (Q_W+1)'(r_s5_ru);
    assign w_q_sat = (r_s5_hi || w_q_inc[Q_W]) ? '1 : w_q_inc[Q_W-1:0];

    always_comb begin
        if (r_s5_neg) begin
            w_val = $signed(V_W'(i_cfg.zp_out)) - $signed(V_W'(w_q_sat));
        end else begin
            w_val = $signed(V_W'(i_cfg.zp_out)) + $signed(V_W'(w_q_sat));
        end
        if (w_val < 0) begin
            w_clamped = '0;
        end else if (w_val > V_W'(PIX_MAX)) begin
            w_clamped = PIX_W'(PIX_MAX);
        end else begin
            w_clamped = w_val[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_emit   <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_single    <= '0;
        end else if (w_adv) begin
            r_s1_valid  <= !i_empty;
            r_s2_valid  <= r_s1_valid;
            r_s2_emit   <= r_s1_valid && r_s1.last_pix;
            r_s3_valid  <= r_s2_emit;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
            if (r_s1_valid && (i_cfg.layout == LAYOUT_CHAN_MAJOR)) begin
                r_single <= w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1         <= i_head;

            r_s2_sum     <= w_sum;
            r_s2_ch      <= r_s1.ch;
            r_s2_last_ch <= r_s1.last_ch;

            r_s3_neg     <= r_s2_sum[ACC_W-1];
            r_s3_mag     <= r_s2_sum[ACC_W-1] ? w_neg_sum[MAG_W-1:0]
                                              : r_s2_sum[MAG_W-1:0];
            r_s3_ch      <= r_s2_ch;
            r_s3_last_ch <= r_s2_last_ch;

            r_s4_prod    <= PROD_W'(r_s3_mag) * PROD_W'(i_cfg.scale_mult);
            r_s4_neg     <= r_s3_neg;
            r_s4_ch      <= r_s3_ch;
            r_s4_last_ch <= r_s3_last_ch;

            r_s5_q       <= w_shifted[Q_W-1:0];
            r_s5_hi      <= |w_shifted[WIDE_W-1:Q_W];
            r_s5_ru      <= w_round_up;
            r_s5_neg     <= r_s4_neg;
            r_s5_ch      <= r_s4_ch;
            r_s5_last_ch <= r_s4_last_ch;

            r_out_value  <= w_clamped;
            r_out_ch     <= r_s5_ch;
            r_out_last   <= r_s5_last_ch;
        end
    end

    assign o_pooled_valid  = r_out_valid;
    assign o_pooled_value  = r_out_value;
    assign o_channel_index = OUT_CH_W'(r_out_ch);
    assign o_last_of_image = r_out_last;

endmodule
